FILE: rtl/depth_point_filter_with_normals_macros.svh
// Assertion macros shared by the checker
`ifndef DEPTH_POINT_FILTER_WITH_NORMALS_MACROS_SVH
`define DEPTH_POINT_FILTER_WITH_NORMALS_MACROS_SVH

// implication checked every clock outside reset
`define DPF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked every clock outside reset
`define DPF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/dpf_pkg.sv
package dpf_pkg;

    localparam int MaxWidthDef = 2048;
    localparam int CoordFracDef = 16;
    localparam int MaxHeight = 4096;

    localparam logic [1:0] RegFrameWidth = 2'd0;
    localparam logic [1:0] RegFrameHeight = 2'd1;
    localparam logic [1:0] RegCoordLimit = 2'd2;

    localparam logic [11:0] ResetWidth = 12'd640;
    localparam logic [12:0] ResetHeight = 13'd480;
    localparam logic [30:0] ResetLimit = 31'd655360;

    // operands of the normal unit
    typedef struct packed {
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] mc;
        logic        neg_a;
        logic        neg_b;
    } t_norm_req;

    // fields of one result word
    typedef struct packed {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [7:0]  gray;
    } t_point;

endpackage

FILE: rtl/dpf_line_buf.sv
// Line buffers: center row gray/x/y/z and upper row z, one read port each,
// registered read data, write-back in the cycle after the read.
module dpf_line_buf
    import dpf_pkg::*;
#(
    parameter int MAX_WIDTH = MaxWidthDef,
    localparam int AW = $clog2(MAX_WIDTH)
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    input  logic [AW-1:0] i_rd_addr_nx,
    output logic [103:0]  o_ctr,
    output logic [31:0]   o_ctr_z_nx,
    output logic [31:0]   o_up_z,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [103:0]  i_wr_ctr,
    input  logic [31:0]   i_wr_up
);

    logic [103:0] r_ctr_mem [MAX_WIDTH];
    logic [31:0]  r_ctrz_mem [MAX_WIDTH];
    logic [31:0]  r_up_mem [MAX_WIDTH];

    // center row word {gray,x,y,z}
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_ctr_mem[i_wr_addr] <= i_wr_ctr;
        end
        if (i_rd_en) begin
            o_ctr <= r_ctr_mem[i_rd_addr];
        end
    end

    // copy of center z for the right neighbor
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_ctrz_mem[i_wr_addr] <= i_wr_ctr[31:0];
        end
        if (i_rd_en) begin
            o_ctr_z_nx <= r_ctrz_mem[i_rd_addr_nx];
        end
    end

    // upper row z
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_up_mem[i_wr_addr] <= i_wr_up;
        end
        if (i_rd_en) begin
            o_up_z <= r_up_mem[i_rd_addr];
        end
    end

endmodule

FILE: rtl/dpf_normal.sv
// Normal unit: normalize, square sum, bit-serial root, serial divides.
module dpf_normal
    import dpf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_norm_req   i_req,
    output logic        o_done,
    output logic [15:0] o_nx,
    output logic [15:0] o_ny,
    output logic [14:0] o_nz
);

    typedef enum logic [2:0] {
        S_IDLE, S_NORM, S_SQ, S_ROOT, S_DIV, S_OUT
    } t_state;

    t_state       r_state;
    logic [31:0]  r_ma, r_mb, r_mc;
    logic         r_na, r_nb;
    logic [1:0]   r_sel;
    logic [63:0]  r_sum;
    logic [63:0]  r_rem;
    logic [31:0]  r_root;
    logic [5:0]   r_cnt;
    logic [63:0]  r_num;
    logic [46:0]  r_q;
    logic [15:0]  r_nx, r_ny;
    logic [14:0]  r_nz;

    logic [31:0]  m_max;
    logic [63:0]  sq_in;
    logic [63:0]  sq;
    logic [65:0]  trial;
    logic [63:0]  rem_sh;
    logic [63:0]  num_sh;
    logic [32:0]  div_trial;
    logic [31:0]  root_nz;
    logic [14:0]  sat;
    logic [31:0]  cur_mag;

    assign m_max = (r_ma > r_mb) ? ((r_ma > r_mc) ? r_ma : r_mc)
                                 : ((r_mb > r_mc) ? r_mb : r_mc);
    assign sq_in = {32'd0, (r_sel == 2'd0) ? r_ma : (r_sel == 2'd1) ? r_mb : r_mc};
    assign sq = sq_in * sq_in;
    // root digit recurrence: two bits of radicand per step
    assign rem_sh = {r_rem[61:0], r_sum[63:62]};
    assign trial = {2'b00, rem_sh} - {32'd0, r_root, 2'b01};
    assign root_nz = (r_root == 32'd0) ? 32'd1 : r_root;
    // restoring divide one bit a step; remainder stays below root (< 2^31)
    assign num_sh = {r_num[62:0], 1'b0};
    assign div_trial = {1'b0, num_sh[63:32]} - {1'b0, root_nz};
    assign sat = (r_q > 47'd16384) ? 15'd16384 : r_q[14:0];
    assign cur_mag = (r_sel == 2'd0) ? r_ma : (r_sel == 2'd1) ? r_mb : r_mc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_ma <= i_req.ma;
                        r_mb <= i_req.mb;
                        r_mc <= i_req.mc;
                        r_na <= i_req.neg_a;
                        r_nb <= i_req.neg_b;
                        r_state <= S_NORM;
                    end
                end
                // one shift a cycle until max lies in [2^29, 2^30)
                S_NORM: begin
                    if (m_max >= 32'h4000_0000) begin
                        r_ma <= r_ma >> 1;
                        r_mb <= r_mb >> 1;
                        r_mc <= r_mc >> 1;
                    end else if (m_max < 32'h2000_0000) begin
                        r_ma <= r_ma << 1;
                        r_mb <= r_mb << 1;
                        r_mc <= r_mc << 1;
                    end else begin
                        r_sel <= 2'd0;
                        r_sum <= 64'd0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_sum <= r_sum + sq;
                    if (r_sel == 2'd2) begin
                        r_rem <= 64'd0;
                        r_root <= 32'd0;
                        r_cnt <= 6'd0;
                        r_state <= S_ROOT;
                    end else begin
                        r_sel <= r_sel + 2'd1;
                    end
                end
                S_ROOT: begin
                    r_sum <= {r_sum[61:0], 2'b00};
                    if (!trial[65]) begin
                        r_rem <= trial[63:0];
                        r_root <= {r_root[30:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_root <= {r_root[30:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd31) begin
                        r_sel <= 2'd0;
                        r_cnt <= 6'd0;
                        r_q <= 47'd0;
                        r_state <= S_DIV;
                    end
                end
                // quotient of (mag*16384 + root/2) / root, one load and 32 steps
                S_DIV: begin
                    if (r_cnt == 6'd0) begin
                        r_num <= {18'd0, cur_mag[31:0], 14'd0} +
                                 {33'd0, root_nz[31:1]};
                        r_q <= 47'd0;
                        r_cnt <= 6'd1;
                    end else begin
                        if (!div_trial[32]) begin
                            r_num <= {div_trial[31:0], num_sh[31:0]};
                            r_q <= {r_q[45:0], 1'b1};
                        end else begin
                            r_num <= num_sh;
                            r_q <= {r_q[45:0], 1'b0};
                        end
                        r_cnt <= r_cnt + 6'd1;
                        if (r_cnt == 6'd32) begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    r_cnt <= 6'd0;
                    case (r_sel)
                        2'd0: r_nx <= r_na ? (16'd0 - {1'b0, sat}) : {1'b0, sat};
                        2'd1: r_ny <= r_nb ? (16'd0 - {1'b0, sat}) : {1'b0, sat};
                        default: r_nz <= sat;
                    endcase
                    if (r_sel == 2'd2) begin
                        o_done <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_sel <= r_sel + 2'd1;
                        r_state <= S_DIV;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_nx = r_nx;
    assign o_ny = r_ny;
    assign o_nz = r_nz;

endmodule

FILE: rtl/depth_point_filter_with_normals.sv
// Depth point filter with surface normals. Pixels enter in raster order; the point
// for row r-1 is judged when the pixel below it arrives. Line buffers sit in
// block memories read in the cycle before the judge and written back in place.
// Pixels that emit no point pass through the idle, read and judge states. A pixel
// that emits a point holds the input until the normal unit finishes (up to 12
// normalize steps, 3 square steps, 32 root steps and three divides of one load
// and 32 steps each) and its result is loaded into the output word. One result
// word is buffered at the output, so the next pixel is taken while it waits.
module depth_point_filter_with_normals
    import dpf_pkg::*;
#(
    parameter int MAX_WIDTH = MaxWidthDef,
    parameter int COORD_FRAC_BITS = CoordFracDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_gray,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_point_x,
    output logic signed [31:0] o_point_y,
    output logic signed [31:0] o_point_z,
    output logic [7:0]         o_point_gray,
    output logic signed [15:0] o_nrm_x,
    output logic signed [15:0] o_nrm_y,
    output logic [14:0]        o_nrm_z,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [30:0]        i_cfg_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = AW + 1;

    typedef enum logic [2:0] {S_IDLE, S_READ, S_JUDGE, S_NORM, S_OUTW} t_state;

    t_state      r_state;
    logic [11:0] r_width;
    logic [12:0] r_height;
    logic [30:0] r_limit;
    logic [CW-1:0] r_col;
    logic [12:0] r_row;
    logic [31:0] r_left;
    logic [103:0] r_pix;
    t_point      r_pt;
    logic        r_ov;
    logic [15:0] r_nx, r_ny;
    logic [14:0] r_nz;
    logic        r_start;
    t_norm_req   r_req;

    logic [12:0] w_eff;
    logic [12:0] h_eff;
    logic        in_frame;
    logic        judge_pos;
    logic [103:0] ctr;
    logic [31:0] ctr_z_nx, up_z;
    logic [AW-1:0] addr, addr_nx;
    logic        wr_en;
    logic [32:0] a_d, b_d;
    logic        pt_ok;
    logic [31:0] ax, ay, az;
    logic        nd;
    logic [15:0] nnx, nny;
    logic [14:0] nnz;

    // effective frame size
    always_comb begin
        w_eff = {1'b0, r_width};
        if (w_eff < 13'd3) w_eff = 13'd3;
        if ({1'b0, w_eff} > 14'(MAX_WIDTH)) w_eff = 13'(MAX_WIDTH);
        h_eff = r_height;
        if (h_eff < 13'd3) h_eff = 13'd3;
        if (h_eff > 13'(MaxHeight)) h_eff = 13'(MaxHeight);
    end

    assign in_frame = (14'(r_col) < {1'b0, w_eff}) && (r_col < CW'(MAX_WIDTH));
    assign addr = r_col[AW-1:0];
    assign addr_nx = AW'(r_col + CW'(1));
    assign judge_pos = in_frame && (r_row >= 13'd2) && (r_col != '0) &&
                       (14'(r_col) + 14'd2 <= {1'b0, w_eff});

    assign ax = ctr[95] ? (32'd0 - ctr[95:64]) : ctr[95:64];
    assign ay = ctr[63] ? (32'd0 - ctr[63:32]) : ctr[63:32];
    assign az = ctr[31] ? (32'd0 - ctr[31:0]) : ctr[31:0];
    assign pt_ok = (ctr[103:96] != 8'd0) && (ax <= {1'b0, r_limit}) &&
                   (ay <= {1'b0, r_limit}) && (az <= {1'b0, r_limit});
    assign a_d = {up_z[31], up_z} - {r_pix[31], r_pix[31:0]};
    assign b_d = {r_left[31], r_left} - {ctr_z_nx[31], ctr_z_nx};

    assign wr_en = (r_state == S_JUDGE) && in_frame;
    assign o_ready = (r_state == S_IDLE);

    dpf_line_buf #(.MAX_WIDTH(MAX_WIDTH)) u_buf (
        .i_clk        (i_clk),
        .i_rd_en      (r_state == S_READ),
        .i_rd_addr    (addr),
        .i_rd_addr_nx (addr_nx),
        .o_ctr        (ctr),
        .o_ctr_z_nx   (ctr_z_nx),
        .o_up_z       (up_z),
        .i_wr_en      (wr_en),
        .i_wr_addr    (addr),
        .i_wr_ctr     (r_pix),
        .i_wr_up      (ctr[31:0])
    );

    dpf_normal u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_req   (r_req),
        .o_done  (nd),
        .o_nx    (nnx),
        .o_ny    (nny),
        .o_nz    (nnz)
    );

    // control sequence, config and output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_width <= ResetWidth;
            r_height <= ResetHeight;
            r_limit <= ResetLimit;
            r_col <= '0;
            r_row <= '0;
            r_left <= '0;
            r_ov <= 1'b0;
            r_start <= 1'b0;
        end else begin
            r_start <= 1'b0;
            // output word: loaded when free or being taken, else cleared once taken
            if ((r_state == S_OUTW) && (!r_ov || i_ready)) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    RegFrameWidth: r_width <= i_cfg_data[11:0];
                    RegFrameHeight: r_height <= i_cfg_data[12:0];
                    RegCoordLimit: r_limit <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_pix <= {i_gray, i_pos_x, i_pos_y, i_pos_z};
                        r_state <= S_READ;
                    end
                end
                S_READ: r_state <= S_JUDGE;
                S_JUDGE: begin
                    if (in_frame) r_left <= ctr[31:0];
                    if (14'(r_col) + 14'd1 >= {1'b0, w_eff}) begin
                        r_col <= '0;
                        r_row <= ({1'b0, r_row} + 14'd1 >= {1'b0, h_eff}) ? 13'd0
                                 : r_row + 13'd1;
                    end else begin
                        r_col <= r_col + CW'(1);
                    end
                    if (judge_pos && pt_ok) begin
                        r_pt <= '{px: ctr[95:64], py: ctr[63:32], pz: ctr[31:0],
                                  gray: ctr[103:96]};
                        r_req <= '{ma: a_d[32] ? 32'(33'd0 - a_d) : a_d[31:0],
                                   mb: b_d[32] ? 32'(33'd0 - b_d) : b_d[31:0],
                                   mc: 32'(64'd1 << (COORD_FRAC_BITS + 1)),
                                   neg_a: a_d[32], neg_b: b_d[32]};
                        r_start <= 1'b1;
                        r_state <= S_NORM;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_NORM: begin
                    if (nd) begin
                        r_nx <= nnx;
                        r_ny <= nny;
                        r_nz <= nnz;
                        r_state <= S_OUTW;
                    end
                end
                S_OUTW: begin
                    if (!r_ov || i_ready) begin
                        o_point_x <= r_pt.px;
                        o_point_y <= r_pt.py;
                        o_point_z <= r_pt.pz;
                        o_point_gray <= r_pt.gray;
                        o_nrm_x <= r_nx;
                        o_nrm_y <= r_ny;
                        o_nrm_z <= r_nz;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_ov;

endmodule

FILE: rtl/dpf_checker.sv
`include "depth_point_filter_with_normals_macros.svh"

// Port-level checks of the filter
module dpf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [14:0] o_nrm_z,
    input logic [31:0] o_point_x
);

    // a waiting word holds its payload
    `DPF_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, $stable(o_point_x))
    // word stays offered until taken
    `DPF_ASSERT_NXT(a_keep, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    // normal z never exceeds one
    `DPF_ASSERT_IMP(a_nz, i_clk, i_rst_n, o_valid, o_nrm_z <= 15'd16384)
    // accepted pixel blocks the input next cycle
    `DPF_ASSERT_NXT(a_seq, i_clk, i_rst_n, i_valid && o_ready, !o_ready)

endmodule

bind depth_point_filter_with_normals dpf_checker u_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .o_ready   (o_ready),
    .o_valid   (o_valid),
    .i_ready   (i_ready),
    .o_nrm_z   (o_nrm_z),
    .o_point_x (o_point_x)
);
